@@ sv/ascii_integer_parser_macros.svh @@
// ascii_integer_parser_macros.svh: assertion macros for the integer parser checks
// expects signals named clock and reset in the scope where a macro is used
`ifndef ASCII_INTEGER_PARSER_MACROS_SVH
`define ASCII_INTEGER_PARSER_MACROS_SVH

// same-cycle implication, disabled during reset
`define AIP_ASSERT_IMPLIES(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, disabled during reset
`define AIP_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ sv/aip_pkg.sv @@
// aip_pkg: types and constants shared by the integer parser modules
// no dependencies
`default_nettype none

package aip_pkg;

   localparam int VALUE_WIDTH_DEF = 32;
   localparam int DCNT_W          = 5;
   localparam int CSR_IDX_W       = 2;
   localparam int CSR_DATA_W      = 5;

   localparam logic [DCNT_W-1:0] DCNT_MAX = '1;

   localparam logic [7:0] CHAR_0     = 8'h30;
   localparam logic [7:0] CHAR_9     = 8'h39;
   localparam logic [7:0] CHAR_LA    = 8'h61;
   localparam logic [7:0] CHAR_LF    = 8'h66;
   localparam logic [7:0] CHAR_UA    = 8'h41;
   localparam logic [7:0] CHAR_UF    = 8'h46;
   localparam logic [7:0] CHAR_SPACE = 8'h20;
   localparam logic [7:0] CHAR_MINUS = 8'h2d;
   localparam logic [7:0] DIGIT_TEN  = 8'd10;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_HEX_MODE    = 2'd0,
      CSR_SIGNED_MODE = 2'd1,
      CSR_DIGIT_LIMIT = 2'd2
   } csr_index_type;

   typedef enum logic [2:0] {
      PH_IDLE   = 3'b001,
      PH_SIGN   = 3'b010,
      PH_DIGITS = 3'b100
   } phase_type;

   typedef struct packed {
      logic              hex_mode;
      logic              signed_mode;
      logic [DCNT_W-1:0] digit_limit;
   } cfg_type;

   typedef struct packed {
      logic       is_space;
      logic       is_minus;
      logic       is_digit;
      logic [3:0] digit_val;
   } char_class_type;

   typedef struct packed {
      logic              emit;
      logic [DCNT_W-1:0] digit_count;
      logic              parse_error;
      logic [7:0]        stop_char;
      logic              stop_char_valid;
   } result_type;

endpackage

`default_nettype wire

@@ sv/aip_if.sv @@
// aip_if: valid/ready stream interfaces for the parser's character and result channels
// depends on aip_pkg
`default_nettype none

interface aip_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] char_code;
   logic       end_of_data;

   modport source (output valid, output char_code, output end_of_data, input ready);
   modport sink   (input valid, input char_code, input end_of_data, output ready);
endinterface

interface aip_rsp_if
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
);
   logic                   valid;
   logic                   ready;
   logic [VALUE_WIDTH-1:0] value_bits;
   logic [DCNT_W-1:0]      digit_count;
   logic                   parse_error;
   logic [7:0]             stop_char;
   logic                   stop_char_valid;

   modport source (output valid, output value_bits, output digit_count, output parse_error,
                   output stop_char, output stop_char_valid, input ready);
   modport sink   (input valid, input value_bits, input digit_count, input parse_error,
                   input stop_char, input stop_char_valid, output ready);
endinterface

`default_nettype wire

@@ sv/aip_char_class.sv @@
// aip_char_class: classifies one character as space, minus or digit of the current base
// depends on aip_pkg
`default_nettype none

module aip_char_class
   import aip_pkg::*;
(
   input  wire logic [7:0]     char_code,
   input  wire logic           hex_mode,
   output char_class_type      char_class
);

   logic       is_dec;
   logic       is_lo;
   logic       is_up;
   logic [7:0] off_dec;
   logic [7:0] off_lo;
   logic [7:0] off_up;

   always_comb begin
      is_dec  = (char_code >= CHAR_0) && (char_code <= CHAR_9);
      is_lo   = hex_mode && (char_code >= CHAR_LA) && (char_code <= CHAR_LF);
      is_up   = hex_mode && (char_code >= CHAR_UA) && (char_code <= CHAR_UF);
      off_dec = char_code - CHAR_0;
      off_lo  = char_code - CHAR_LA + DIGIT_TEN;
      off_up  = char_code - CHAR_UA + DIGIT_TEN;

      char_class.is_space = (char_code == CHAR_SPACE);
      char_class.is_minus = (char_code == CHAR_MINUS);
      char_class.is_digit = is_dec || is_lo || is_up;
      if (is_dec) begin
         char_class.digit_val = off_dec[3:0];
      end else if (is_lo) begin
         char_class.digit_val = off_lo[3:0];
      end else begin
         char_class.digit_val = off_up[3:0];
      end
   end

endmodule

`default_nettype wire

@@ sv/aip_parse_core.sv @@
// aip_parse_core: parse state (phase, accumulator, digit count, sign) and result logic
// depends on aip_pkg; fed by aip_char_class
`default_nettype none

module aip_parse_core
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   advance,
   input  wire logic [7:0]             char_code,
   input  wire logic                   end_of_data,
   input  wire char_class_type         char_class,
   input  wire cfg_type                cfg,
   output result_type                  result,
   output logic [VALUE_WIDTH-1:0]      value_bits
);

   phase_type              phase_ff, phase_in;
   logic [VALUE_WIDTH-1:0] acc_ff, acc_in;
   logic [DCNT_W-1:0]      digits_ff, digits_in;
   logic                   neg_ff, neg_in;

   logic                   skipping;
   logic [VALUE_WIDTH-1:0] acc_step;
   logic [DCNT_W-1:0]      digits_step;
   logic [VALUE_WIDTH-1:0] acc_sel;
   logic [DCNT_W-1:0]      digits_sel;
   logic                   neg_sel;
   logic                   limit_hit;

   always_comb begin
      skipping = (phase_ff == PH_IDLE) || (phase_ff == PH_SIGN);
      if (cfg.hex_mode) begin
         acc_step = (acc_ff << 4) | VALUE_WIDTH'(char_class.digit_val);
      end else begin
         // times ten as shift-and-add
         acc_step = (acc_ff << 3) + (acc_ff << 1) + VALUE_WIDTH'(char_class.digit_val);
      end
      digits_step = (digits_ff == DCNT_MAX) ? digits_ff : digits_ff + 1'b1;
      limit_hit   = (cfg.digit_limit != '0) && (digits_step >= cfg.digit_limit);

      phase_in   = phase_ff;
      acc_in     = acc_ff;
      digits_in  = digits_ff;
      neg_in     = neg_ff;
      acc_sel    = acc_ff;
      digits_sel = digits_ff;
      neg_sel    = neg_ff;
      result.emit            = 1'b0;
      result.stop_char       = '0;
      result.stop_char_valid = 1'b0;

      if (skipping && char_class.is_space) begin
         result.emit = end_of_data;
      end else if ((phase_ff == PH_IDLE) && cfg.signed_mode && char_class.is_minus) begin
         phase_in    = PH_SIGN;
         neg_in      = 1'b1;
         neg_sel     = 1'b1;
         result.emit = end_of_data;
      end else if (!char_class.is_digit) begin
         // terminator is handed back unconsumed
         result.emit            = 1'b1;
         result.stop_char       = char_code;
         result.stop_char_valid = 1'b1;
      end else begin
         phase_in    = PH_DIGITS;
         acc_in      = acc_step;
         digits_in   = digits_step;
         acc_sel     = acc_step;
         digits_sel  = digits_step;
         result.emit = end_of_data || limit_hit;
      end

      result.digit_count = digits_sel;
      result.parse_error = (digits_sel == '0);
      if (result.parse_error) begin
         value_bits = '0;
      end else if (neg_sel) begin
         value_bits = ~acc_sel + 1'b1;
      end else begin
         value_bits = acc_sel;
      end

      if (result.emit) begin
         phase_in  = PH_IDLE;
         acc_in    = '0;
         digits_in = '0;
         neg_in    = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= PH_IDLE;
         acc_ff    <= '0;
         digits_ff <= '0;
         neg_ff    <= 1'b0;
      end else if (advance) begin
         phase_ff  <= phase_in;
         acc_ff    <= acc_in;
         digits_ff <= digits_in;
         neg_ff    <= neg_in;
      end
   end

endmodule

`default_nettype wire

@@ sv/ascii_integer_parser.sv @@
// ascii_integer_parser: top level, with character input register, result register and csrs
// depends on aip_pkg, aip_if, aip_char_class, aip_parse_core
//
// Usage:
//   req_ch carries one character per transaction (char_code, end_of_data).
//   rsp_ch carries one result per parsed number: value_bits, digit_count,
//   parse_error, stop_char and stop_char_valid.
//   csr_wr_en/csr_index/csr_data write hex_mode (0), signed_mode (1) and
//   digit_limit (2); write only while no number is in progress.
// Timing:
//   a character is registered at acceptance and evaluated against the parse
//   state once the result register is free, and the result that it ends is
//   then held in the result register, which drives rsp_ch.
//   one character per cycle is sustained while rsp_ch does not stall; the
//   parse state loop updates directly from the registered character.
// Reset:
//   synchronous, clears the parse state, the csrs and both valid flags.
// Backpressure:
//   while a result waits on rsp_ch the registered character holds and
//   req_ch.ready stays high only until that register is occupied.
`default_nettype none

module ascii_integer_parser
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input  wire logic                  clock,
   input  wire logic                  reset,
   aip_req_if.sink                    req_ch,
   aip_rsp_if.source                  rsp_ch,
   input  wire logic                  csr_wr_en,
   input  wire logic [CSR_IDX_W-1:0]  csr_index,
   input  wire logic [CSR_DATA_W-1:0] csr_data
);

   cfg_type                cfg_ff;
   logic                   in_valid_ff;
   logic [7:0]             char_ff;
   logic                   eod_ff;
   logic                   out_valid_ff;
   logic [VALUE_WIDTH-1:0] value_ff;
   result_type             res_ff;

   logic                   advance;
   logic                   in_take;
   char_class_type         char_class;
   result_type             result;
   logic [VALUE_WIDTH-1:0] value_bits;

   assign advance       = in_valid_ff && (!out_valid_ff || rsp_ch.ready);
   assign req_ch.ready  = !in_valid_ff || advance;
   assign in_take       = req_ch.valid && req_ch.ready;

   aip_char_class u_char_class (
      .char_code  (char_ff),
      .hex_mode   (cfg_ff.hex_mode),
      .char_class (char_class)
   );

   aip_parse_core #(
      .VALUE_WIDTH (VALUE_WIDTH)
   ) u_parse_core (
      .clock       (clock),
      .reset       (reset),
      .advance     (advance),
      .char_code   (char_ff),
      .end_of_data (eod_ff),
      .char_class  (char_class),
      .cfg         (cfg_ff),
      .result      (result),
      .value_bits  (value_bits)
   );

   // csr writes
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '0;
      end else if (csr_wr_en) begin
         unique case (csr_index)
            CSR_HEX_MODE:    cfg_ff.hex_mode    <= csr_data[0];
            CSR_SIGNED_MODE: cfg_ff.signed_mode <= csr_data[0];
            CSR_DIGIT_LIMIT: cfg_ff.digit_limit <= csr_data[DCNT_W-1:0];
            default: ;
         endcase
      end
   end

   // input register
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (in_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (in_take) begin
         char_ff <= req_ch.char_code;
         eod_ff  <= req_ch.end_of_data;
      end
   end

   // result register
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= result.emit;
      end else if (rsp_ch.ready) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance && result.emit) begin
         value_ff <= value_bits;
         res_ff   <= result;
      end
   end

   assign rsp_ch.valid           = out_valid_ff;
   assign rsp_ch.value_bits      = value_ff;
   assign rsp_ch.digit_count     = res_ff.digit_count;
   assign rsp_ch.parse_error     = res_ff.parse_error;
   assign rsp_ch.stop_char       = res_ff.stop_char;
   assign rsp_ch.stop_char_valid = res_ff.stop_char_valid;

endmodule

`default_nettype wire

@@ sv/aip_checker.sv @@
// aip_checker: port-level checks of the integer parser result channel, bound to the top
// depends on aip_pkg and ascii_integer_parser_macros.svh
`default_nettype none
`include "ascii_integer_parser_macros.svh"

module aip_checker
   import aip_pkg::*;
#(
   parameter int VALUE_WIDTH = VALUE_WIDTH_DEF
) (
   input wire logic                   clock,
   input wire logic                   reset,
   input wire logic                   rsp_valid,
   input wire logic                   rsp_ready,
   input wire logic [VALUE_WIDTH-1:0] value_bits,
   input wire logic [DCNT_W-1:0]      digit_count,
   input wire logic                   parse_error,
   input wire logic [7:0]             stop_char,
   input wire logic                   stop_char_valid
);

   // a stalled result transaction keeps its value, digit count and stop char
   `AIP_ASSERT_NEXT(a_rsp_hold, rsp_valid && !rsp_ready, rsp_valid && $stable(value_bits) && $stable(digit_count) && $stable(stop_char), "result changed while stalled")

   `AIP_ASSERT_IMPLIES(a_err_zero, rsp_valid && parse_error, (value_bits == '0) && (digit_count == '0), "error result carries value or digits")

   `AIP_ASSERT_IMPLIES(a_ok_digits, rsp_valid && !parse_error, digit_count != '0, "good result without digits")

   `AIP_ASSERT_IMPLIES(a_stop_clear, rsp_valid && !stop_char_valid, stop_char == '0, "stop char set without valid flag")

   `AIP_ASSERT_IMPLIES(a_reset_idle, $past(reset), !rsp_valid, "result valid right after reset")

endmodule

bind ascii_integer_parser aip_checker #(
   .VALUE_WIDTH (VALUE_WIDTH)
) u_aip_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_ch.valid),
   .rsp_ready       (rsp_ch.ready),
   .value_bits      (rsp_ch.value_bits),
   .digit_count     (rsp_ch.digit_count),
   .parse_error     (rsp_ch.parse_error),
   .stop_char       (rsp_ch.stop_char),
   .stop_char_valid (rsp_ch.stop_char_valid)
);

`default_nettype wire
